FILE: rtl/osfm_pkg.sv
// Shared types, constants and helpers of the octant field map unit.
package osfm_pkg;

  // Default sizes of the table and of the interpolation fraction.
  localparam int unsigned DEF_TABLE_DEPTH   = 32768;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned RECIP_W  = 24;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned LIDX_W   = 15;
  localparam int unsigned GRID_W   = POS_W + RECIP_W;  // scaled coordinate, 32 fraction bits
  localparam int unsigned IDX_W    = GRID_W - 32;      // integer part of the coordinate
  localparam int unsigned T1_W     = 17;               // i * size_y + j
  localparam int unsigned SYZ_W    = 2 * SIZE_W;       // size_y * size_z
  localparam int unsigned BASE_W   = 26;               // (i * size_y + j) * size_z + k
  localparam int unsigned NADDR_W  = BASE_W + 1;       // base plus a neighbor offset
  localparam int unsigned CORNERS  = 8;
  localparam int unsigned COMPS    = 3;

  // Register map, one word each at byte address 4 * index.
  typedef enum logic [2:0] {
    REG_SIZE_X       = 3'd0,
    REG_SIZE_Y       = 3'd1,
    REG_SIZE_Z       = 3'd2,
    REG_RECIP_X      = 3'd3,
    REG_RECIP_Y      = 3'd4,
    REG_RECIP_Z      = 3'd5,
    REG_FIELD_SCALE  = 3'd6,
    REG_HANDOFF_EN   = 3'd7
  } reg_idx_e;

  // Item function codes.
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  // Three field components of one table entry: 0 is x, 1 is y, 2 is z.
  typedef logic [COMPS-1:0][SAMPLE_W-1:0] sample3_t;

  // Per-query flags that travel beside the arithmetic.
  typedef struct packed {
    logic in_grid;
    logic flip_x;
    logic flip_z;
    logic hand_off;
  } flags_t;

  // Magnitude of a signed position; the most negative value maps to 2^31.
  function automatic logic [POS_W-1:0] abs_pos(input logic signed [POS_W-1:0] p);
    abs_pos = p[POS_W-1] ? (~p + POS_W'(1)) : p;
  endfunction

endpackage

FILE: rtl/osfm_ram.sv
// One sample memory with a write port and a registered read port.
module osfm_ram #(
  parameter int unsigned DEPTH = osfm_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned AW    = $clog2(osfm_pkg::DEF_TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  osfm_pkg::sample3_t wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output osfm_pkg::sample3_t rdata_o
);
  import osfm_pkg::*;

  sample3_t mem [DEPTH];
  sample3_t rdata_q;

  // Write on a load, read on a query; the read word holds while stalled.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/osfm_locate.sv
// Stages one to three: scales the position, splits it into grid index and fraction,
// checks the grid bounds and forms the base table address.
module osfm_locate #(
  parameter int unsigned FRACTION_BITS = osfm_pkg::DEF_FRACTION_BITS
) (
  input  logic                                 clk_i,
  input  logic [2:0]                           en_i,
  input  logic                                 func_i,
  input  logic [osfm_pkg::LIDX_W-1:0]          load_index_i,
  input  osfm_pkg::sample3_t                   load_data_i,
  input  logic signed [osfm_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [osfm_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [osfm_pkg::POS_W-1:0]    pos_z_i,
  input  logic                                 on_source_axis_i,
  input  logic [osfm_pkg::SIZE_W-1:0]          size_x_i,
  input  logic [osfm_pkg::SIZE_W-1:0]          size_y_i,
  input  logic [osfm_pkg::SIZE_W-1:0]          size_z_i,
  input  logic [osfm_pkg::RECIP_W-1:0]         recip_x_i,
  input  logic [osfm_pkg::RECIP_W-1:0]         recip_y_i,
  input  logic [osfm_pkg::RECIP_W-1:0]         recip_z_i,
  input  logic                                 handoff_enable_i,
  output logic                                 func_o,
  output logic [osfm_pkg::LIDX_W-1:0]          load_index_o,
  output osfm_pkg::sample3_t                   load_data_o,
  output logic [osfm_pkg::BASE_W-1:0]          base_o,
  output logic [osfm_pkg::SYZ_W-1:0]           syz_o,
  output logic [FRACTION_BITS-1:0]             frac_x_o,
  output logic [FRACTION_BITS-1:0]             frac_y_o,
  output logic [FRACTION_BITS-1:0]             frac_z_o,
  output osfm_pkg::flags_t                     flags_o
);
  import osfm_pkg::*;

  // Stage one registers.
  logic              func1_q;
  logic [LIDX_W-1:0] lidx1_q;
  sample3_t          ldata1_q;
  logic              nx1_q, ny1_q, nz1_q, src1_q;
  logic [GRID_W-1:0] gx_q, gy_q, gz_q;
  logic [GRID_W-1:0] gx_d, gy_d, gz_d;

  // Stage two registers.
  logic              func2_q;
  logic [LIDX_W-1:0] lidx2_q;
  sample3_t          ldata2_q;
  logic [T1_W-1:0]   t1_q, t1_d;
  logic [7:0]        k2_q;
  logic [SYZ_W-1:0]  syz2_q, syz_d;
  logic [FRACTION_BITS-1:0] fx2_q, fy2_q, fz2_q;
  flags_t            flags2_q, flags_d;

  // Stage three registers.
  logic              func3_q;
  logic [LIDX_W-1:0] lidx3_q;
  sample3_t          ldata3_q;
  logic [BASE_W-1:0] base_q, base_d;
  logic [SYZ_W-1:0]  syz3_q;
  logic [FRACTION_BITS-1:0] fx3_q, fy3_q, fz3_q;
  flags_t            flags3_q;

  logic [IDX_W-1:0]  idx_x, idx_y, idx_z;
  logic              in_x, in_y, in_z;

  // Absolute coordinate times reciprocal spacing.
  assign gx_d = GRID_W'(abs_pos(pos_x_i)) * GRID_W'(recip_x_i);
  assign gy_d = GRID_W'(abs_pos(pos_y_i)) * GRID_W'(recip_y_i);
  assign gz_d = GRID_W'(abs_pos(pos_z_i)) * GRID_W'(recip_z_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      func1_q  <= func_i;
      lidx1_q  <= load_index_i;
      ldata1_q <= load_data_i;
      nx1_q    <= pos_x_i[POS_W-1];
      ny1_q    <= pos_y_i[POS_W-1];
      nz1_q    <= pos_z_i[POS_W-1];
      src1_q   <= on_source_axis_i;
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      gz_q     <= gz_d;
    end
  end

  // Index and fraction split, bounds check and first address product.
  assign idx_x = gx_q[GRID_W-1:32];
  assign idx_y = gy_q[GRID_W-1:32];
  assign idx_z = gz_q[GRID_W-1:32];

  assign in_x = (size_x_i >= SIZE_W'(2)) && (idx_x < (IDX_W'(size_x_i) - IDX_W'(1)));
  assign in_y = (size_y_i >= SIZE_W'(2)) && (idx_y < (IDX_W'(size_y_i) - IDX_W'(1)));
  assign in_z = (size_z_i >= SIZE_W'(2)) && (idx_z < (IDX_W'(size_z_i) - IDX_W'(1)));

  always_comb begin
    flags_d.in_grid  = in_x && in_y && in_z;
    flags_d.flip_x   = nx1_q ^ ny1_q;
    flags_d.flip_z   = ny1_q ^ nz1_q;
    flags_d.hand_off = in_x && in_y && in_z && handoff_enable_i && src1_q && nx1_q;
  end

  assign t1_d  = T1_W'(idx_x[7:0]) * T1_W'(size_y_i) + T1_W'(idx_y[7:0]);
  assign syz_d = SYZ_W'(size_y_i) * SYZ_W'(size_z_i);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      func2_q  <= func1_q;
      lidx2_q  <= lidx1_q;
      ldata2_q <= ldata1_q;
      t1_q     <= t1_d;
      k2_q     <= idx_z[7:0];
      syz2_q   <= syz_d;
      fx2_q    <= gx_q[31 -: FRACTION_BITS];
      fy2_q    <= gy_q[31 -: FRACTION_BITS];
      fz2_q    <= gz_q[31 -: FRACTION_BITS];
      flags2_q <= flags_d;
    end
  end

  // Base address of the lower corner.
  assign base_d = BASE_W'(t1_q) * BASE_W'(size_z_i) + BASE_W'(k2_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      func3_q  <= func2_q;
      lidx3_q  <= lidx2_q;
      ldata3_q <= ldata2_q;
      base_q   <= base_d;
      syz3_q   <= syz2_q;
      fx3_q    <= fx2_q;
      fy3_q    <= fy2_q;
      fz3_q    <= fz2_q;
      flags3_q <= flags2_q;
    end
  end

  assign func_o       = func3_q;
  assign load_index_o = lidx3_q;
  assign load_data_o  = ldata3_q;
  assign base_o       = base_q;
  assign syz_o        = syz3_q;
  assign frac_x_o     = fx3_q;
  assign frac_y_o     = fy3_q;
  assign frac_z_o     = fz3_q;
  assign flags_o      = flags3_q;

endmodule

FILE: rtl/osfm_blend.sv
// Stages five to nine: z, y and x interpolation, scaling, rounding, sign
// correction and saturation of the three field components.
module osfm_blend #(
  parameter int unsigned FRACTION_BITS = osfm_pkg::DEF_FRACTION_BITS
) (
  input  logic                                  clk_i,
  input  logic [4:0]                            en_i,
  input  osfm_pkg::sample3_t                    smp_i [osfm_pkg::CORNERS],
  input  logic [FRACTION_BITS-1:0]              frac_x_i,
  input  logic [FRACTION_BITS-1:0]              frac_y_i,
  input  logic [FRACTION_BITS-1:0]              frac_z_i,
  input  osfm_pkg::flags_t                      flags_i,
  input  logic signed [osfm_pkg::SCALE_W-1:0]   scale_i,
  output logic signed [osfm_pkg::SAMPLE_W-1:0]  field_x_o,
  output logic signed [osfm_pkg::SAMPLE_W-1:0]  field_y_o,
  output logic signed [osfm_pkg::SAMPLE_W-1:0]  field_z_o,
  output logic                                  inside_res_o,
  output logic                                  hand_off_o
);
  import osfm_pkg::*;

  localparam int unsigned PW  = SAMPLE_W + 2 + FRACTION_BITS;
  localparam int unsigned SPW = SAMPLE_W + SCALE_W;
  localparam int unsigned RW  = SPW + 1;

  // a + round_half_up((b - a) * f / 2^F), which equals the weighted blend.
  function automatic logic signed [SAMPLE_W-1:0] lerp(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [FRACTION_BITS-1:0]   f
  );
    logic signed [SAMPLE_W:0] d;
    logic signed [PW-1:0]     p;
    logic signed [PW-1:0]     r;
    d = (SAMPLE_W + 1)'(b) - (SAMPLE_W + 1)'(a);
    p = PW'(d) * PW'(signed'({1'b0, f}));
    r = (p + (PW'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    lerp = SAMPLE_W'(a + r[SAMPLE_W-1:0]);
  endfunction

  logic signed [SAMPLE_W-1:0] z_q [COMPS][4];
  logic signed [SAMPLE_W-1:0] y_q [COMPS][2];
  logic signed [SAMPLE_W-1:0] x_q [COMPS];
  logic signed [SPW-1:0]      p_q [COMPS];
  logic signed [SAMPLE_W-1:0] f_q [COMPS];
  logic signed [SAMPLE_W-1:0] f_d [COMPS];
  logic [FRACTION_BITS-1:0]   fx5_q, fy5_q, fx6_q;
  flags_t                     flg5_q, flg6_q, flg7_q, flg8_q;
  logic                       inside9_q, hand9_q;

  // Stage five: blend along z.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int c = 0; c < COMPS; c++) begin
        for (int m = 0; m < 4; m++) begin
          z_q[c][m] <= lerp(signed'(smp_i[2*m][c]), signed'(smp_i[2*m+1][c]), frac_z_i);
        end
      end
      fx5_q  <= frac_x_i;
      fy5_q  <= frac_y_i;
      flg5_q <= flags_i;
    end
  end

  // Stage six: blend along y.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int c = 0; c < COMPS; c++) begin
        y_q[c][0] <= lerp(z_q[c][0], z_q[c][1], fy5_q);
        y_q[c][1] <= lerp(z_q[c][2], z_q[c][3], fy5_q);
      end
      fx6_q  <= fx5_q;
      flg6_q <= flg5_q;
    end
  end

  // Stage seven: blend along x.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int c = 0; c < COMPS; c++) begin
        x_q[c] <= lerp(y_q[c][0], y_q[c][1], fx6_q);
      end
      flg7_q <= flg6_q;
    end
  end

  // Stage eight: multiply by the field scale.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int c = 0; c < COMPS; c++) begin
        p_q[c] <= SPW'(x_q[c]) * SPW'(scale_i);
      end
      flg8_q <= flg7_q;
    end
  end

  // Stage nine: round, flip sign per octant, saturate, zero when outside.
  always_comb begin
    logic signed [RW-1:0] r;
    logic                 flip;
    for (int c = 0; c < COMPS; c++) begin
      r    = (RW'(p_q[c]) + RW'(32768)) >>> 16;
      flip = (c == 0) ? flg8_q.flip_x : ((c == 2) ? flg8_q.flip_z : 1'b0);
      if (flip) begin
        r = -r;
      end
      if (!flg8_q.in_grid) begin
        f_d[c] = '0;
      end else if (r > RW'(32'sh7FFF_FFFF)) begin
        f_d[c] = 32'sh7FFF_FFFF;
      end else if (r < RW'(-64'sd2147483648)) begin
        f_d[c] = 32'sh8000_0000;
      end else begin
        f_d[c] = r[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int c = 0; c < COMPS; c++) begin
        f_q[c] <= f_d[c];
      end
      inside9_q <= flg8_q.in_grid;
      hand9_q   <= flg8_q.hand_off;
    end
  end

  assign field_x_o    = f_q[0];
  assign field_y_o    = f_q[1];
  assign field_z_o    = f_q[2];
  assign inside_res_o = inside9_q;
  assign hand_off_o   = hand9_q;

endmodule

FILE: rtl/octant_symmetric_field_map_trilinear_unit.sv
// Top level of the octant-symmetric trilinear field map unit.
// Usage: program the grid sizes, reciprocal spacings, field scale and hand-off
// enable through the APB-style port while no word is in flight. Then send words
// on the input channel: a load word (func 0) writes the three field samples of one
// table entry, a query word (func 1) returns one result word on the output channel.
// Loads give no result word and must precede any query that reads their entry.
// Throughput: one word per cycle unless stalled; eight copies of the sample table
// give the eight corner reads of a query in the same cycle, and nine register
// stages carry the scaling, address, interpolation and output arithmetic.
// Stall: when the receiver holds ready low, the output stage holds its word and
// earlier stages keep filling empty slots until the pipeline is full; then
// in_ready_o drops. Nothing is lost or repeated.
// Reset: all stages empty, registers at their default values (sizes 2, spacings
// and scale 1.0, hand-off off). Table contents are undefined until loaded.
module octant_symmetric_field_map_trilinear_unit #(
  parameter int unsigned TABLE_DEPTH   = osfm_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned FRACTION_BITS = osfm_pkg::DEF_FRACTION_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [4:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [osfm_pkg::LIDX_W-1:0]          load_index_i,
  input  logic signed [osfm_pkg::SAMPLE_W-1:0] load_bx_i,
  input  logic signed [osfm_pkg::SAMPLE_W-1:0] load_by_i,
  input  logic signed [osfm_pkg::SAMPLE_W-1:0] load_bz_i,
  input  logic signed [osfm_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [osfm_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [osfm_pkg::POS_W-1:0]    pos_z_i,
  input  logic                                 on_source_axis_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [osfm_pkg::SAMPLE_W-1:0] field_x_o,
  output logic signed [osfm_pkg::SAMPLE_W-1:0] field_y_o,
  output logic signed [osfm_pkg::SAMPLE_W-1:0] field_z_o,
  output logic                                 inside_res_o,
  output logic                                 hand_off_o
);
  import osfm_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NS = 9;

  // Configuration registers.
  logic [SIZE_W-1:0]         size_x_q, size_y_q, size_z_q;
  logic [RECIP_W-1:0]        recip_x_q, recip_y_q, recip_z_q;
  logic signed [SCALE_W-1:0] scale_q;
  logic                      handoff_en_q;
  logic                      cfg_we;

  // Pipeline control.
  logic [NS:1] v_q;
  logic [NS:1] en;

  // Stage three outputs.
  logic                     func3;
  logic [LIDX_W-1:0]        lidx3;
  sample3_t                 ldata3;
  logic [BASE_W-1:0]        base3;
  logic [SYZ_W-1:0]         syz3;
  logic [FRACTION_BITS-1:0] fx3, fy3, fz3;
  flags_t                   flags3;

  // Stage four: table access.
  sample3_t                 load_data;
  sample3_t                 smp [CORNERS];
  logic [AW-1:0]            raddr [CORNERS];
  logic                     mem_we, mem_re;
  logic                     query4_q;
  logic [FRACTION_BITS-1:0] fx4_q, fy4_q, fz4_q;
  flags_t                   flags4_q;

  // Register writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q     <= SIZE_W'(2);
      size_y_q     <= SIZE_W'(2);
      size_z_q     <= SIZE_W'(2);
      recip_x_q    <= RECIP_W'(65536);
      recip_y_q    <= RECIP_W'(65536);
      recip_z_q    <= RECIP_W'(65536);
      scale_q      <= SCALE_W'(65536);
      handoff_en_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_SIZE_X:      size_x_q     <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:      size_y_q     <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:      size_z_q     <= pwdata[SIZE_W-1:0];
        REG_RECIP_X:     recip_x_q    <= pwdata[RECIP_W-1:0];
        REG_RECIP_Y:     recip_y_q    <= pwdata[RECIP_W-1:0];
        REG_RECIP_Z:     recip_z_q    <= pwdata[RECIP_W-1:0];
        REG_FIELD_SCALE: scale_q      <= pwdata[SCALE_W-1:0];
        REG_HANDOFF_EN:  handoff_en_q <= pwdata[0];
        default:         handoff_en_q <= handoff_en_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      REG_SIZE_X:      prdata = 32'(size_x_q);
      REG_SIZE_Y:      prdata = 32'(size_y_q);
      REG_SIZE_Z:      prdata = 32'(size_z_q);
      REG_RECIP_X:     prdata = 32'(recip_x_q);
      REG_RECIP_Y:     prdata = 32'(recip_y_q);
      REG_RECIP_Z:     prdata = 32'(recip_z_q);
      REG_FIELD_SCALE: prdata = 32'(scale_q);
      REG_HANDOFF_EN:  prdata = 32'(handoff_en_q);
      default:         prdata = '0;
    endcase
  end

  // A stage loads when it is empty or its word moves on.
  always_comb begin
    en[NS] = !v_q[NS] || out_ready_i;
    for (int s = NS - 1; s >= 1; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NS];

  // Valid bits; loads leave the pipeline after the table stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 1; s <= NS; s++) begin
        if (en[s]) begin
          if (s == 1) begin
            v_q[s] <= in_valid_i;
          end else if (s == 5) begin
            v_q[s] <= v_q[4] && query4_q;
          end else begin
            v_q[s] <= v_q[s-1];
          end
        end
      end
    end
  end

  assign load_data[0] = load_bx_i;
  assign load_data[1] = load_by_i;
  assign load_data[2] = load_bz_i;

  osfm_locate #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_locate (
    .clk_i           (clk_i),
    .en_i            (en[3:1]),
    .func_i          (func_i),
    .load_index_i    (load_index_i),
    .load_data_i     (load_data),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .on_source_axis_i(on_source_axis_i),
    .size_x_i        (size_x_q),
    .size_y_i        (size_y_q),
    .size_z_i        (size_z_q),
    .recip_x_i       (recip_x_q),
    .recip_y_i       (recip_y_q),
    .recip_z_i       (recip_z_q),
    .handoff_enable_i(handoff_en_q),
    .func_o          (func3),
    .load_index_o    (lidx3),
    .load_data_o     (ldata3),
    .base_o          (base3),
    .syz_o           (syz3),
    .frac_x_o        (fx3),
    .frac_y_o        (fy3),
    .frac_z_o        (fz3),
    .flags_o         (flags3)
  );

  // Table stage: loads write all copies, queries read one corner per copy.
  assign mem_we = en[4] && v_q[3] && (func3 == FUNC_LOAD) &&
                  (32'(lidx3) < 32'(TABLE_DEPTH));
  assign mem_re = en[4] && v_q[3] && (func3 == FUNC_QUERY);

  for (genvar q = 0; q < CORNERS; q++) begin : g_corner
    logic [NADDR_W-1:0] n;
    assign n = NADDR_W'(base3)
             + ((q & 1) != 0 ? NADDR_W'(1) : NADDR_W'(0))
             + ((q & 2) != 0 ? NADDR_W'(size_z_q) : NADDR_W'(0))
             + ((q & 4) != 0 ? NADDR_W'(syz3) : NADDR_W'(0));
    assign raddr[q] = n[AW-1:0];

    osfm_ram #(
      .DEPTH(TABLE_DEPTH),
      .AW   (AW)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (mem_we),
      .waddr_i(AW'(lidx3)),
      .wdata_i(ldata3),
      .re_i   (mem_re),
      .raddr_i(raddr[q]),
      .rdata_o(smp[q])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      query4_q <= (func3 == FUNC_QUERY);
      fx4_q    <= fx3;
      fy4_q    <= fy3;
      fz4_q    <= fz3;
      flags4_q <= flags3;
    end
  end

  osfm_blend #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .en_i        (en[9:5]),
    .smp_i       (smp),
    .frac_x_i    (fx4_q),
    .frac_y_i    (fy4_q),
    .frac_z_i    (fz4_q),
    .flags_i     (flags4_q),
    .scale_i     (scale_q),
    .field_x_o   (field_x_o),
    .field_y_o   (field_y_o),
    .field_z_o   (field_z_o),
    .inside_res_o(inside_res_o),
    .hand_off_o  (hand_off_o)
  );

`ifndef SYNTHESIS
  // A table write and a table read never share a cycle.
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("table write and read in the same cycle");

  // An outside result carries zero field and no hand-off.
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |->
      field_x_o == 0 && field_y_o == 0 && field_z_o == 0 && !hand_off_o)
    else $error("outside result with nonzero field");

  // Hand-off is only raised inside the grid.
  a_handoff_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hand_off_o |-> inside_res_o)
    else $error("hand-off outside the grid");

  // The input side only stalls when the first stage holds a word.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v_q[1])
    else $error("input stalled with empty first stage");

  // A stalled result word stays valid.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_x_o))
    else $error("result word dropped while stalled");
`endif

endmodule
